/* hdl/scam_pkg.sv */
`timescale 1ns / 1ps

package scam_pkg;

	// quotient of a 32-bit offset by 254 fits in 25 bits
	localparam int QW      = 25;
	localparam int ENTRY_W = 12;
	localparam int TRK_W   = 7;
	localparam int SEC_W   = 5;

	// (off >> 1) / 127 by reciprocal: ceil(2^38 / 127)
	localparam logic [31:0] RECIP_127   = 32'd2164392969;
	localparam int          RECIP_SHIFT = 38;
	localparam logic [7:0]  DATA_BYTES  = 8'd254;

	// op codes
	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_WRITE  = 3'd3;
	localparam logic [2:0] OP_SIZE   = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_TRACK  = 3'd2;
	localparam logic [2:0] ST_SECTOR = 3'd3;
	localparam logic [2:0] ST_CHAIN  = 3'd4;
	localparam logic [2:0] ST_IMAGE  = 3'd5;
	localparam logic [2:0] ST_WRDIS  = 3'd6;
	localparam logic [2:0] ST_CLOSED = 3'd7;

	// image kinds and register indexes
	localparam logic [1:0] KIND_D64 = 2'd0;
	localparam logic [1:0] KIND_D80 = 2'd1;

	localparam logic [1:0] REG_KIND   = 2'd0;
	localparam logic [1:0] REG_BYTES  = 2'd1;
	localparam logic [1:0] REG_WRITES = 2'd2;

	localparam logic [31:0] IMAGE_BYTES_RST = 32'd174848;

	// controller to datapath commands
	typedef struct packed {
		logic cap;
		logic mul;
		logic fix;
		logic rd;
		logic map;
		logic load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_map;
	} sts_t;

	// sectors per track in the zone of a track
	function automatic logic [4:0] zone_sectors(input logic d80, input logic [7:0] trk);
		logic [4:0] r;
		if (d80) begin
			if (trk <= 8'd39) r = 5'd29;
			else if (trk <= 8'd53) r = 5'd27;
			else if (trk <= 8'd64) r = 5'd25;
			else r = 5'd23;
		end else begin
			if (trk <= 8'd17) r = 5'd21;
			else if (trk <= 8'd24) r = 5'd19;
			else if (trk <= 8'd30) r = 5'd18;
			else r = 5'd17;
		end
		return r;
	endfunction

	function automatic logic [7:0] track_count(input logic d80);
		return d80 ? 8'd77 : 8'd35;
	endfunction

	// sectors stored ahead of a track, closed form per zone
	function automatic logic [11:0] track_base(input logic d80, input logic [6:0] trk);
		int t;
		int r;
		t = (trk > 7'd78) ? 78 : int'(trk);
		if (t == 0) r = 0;
		else if (d80) begin
			if (t <= 39) r = (t - 1) * 29;
			else if (t <= 53) r = 1131 + (t - 40) * 27;
			else if (t <= 64) r = 1509 + (t - 54) * 25;
			else r = 1784 + (t - 65) * 23;
		end else begin
			if (t <= 17) r = (t - 1) * 21;
			else if (t <= 24) r = 357 + (t - 18) * 19;
			else if (t <= 30) r = 490 + (t - 25) * 18;
			else r = 598 + (t - 31) * 17;
		end
		return 12'(r);
	endfunction

endpackage

/* hdl/scam_ram.sv */
`timescale 1ns / 1ps

module scam_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/scam_ctrl.sv */
`timescale 1ns / 1ps

module scam_ctrl import scam_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVQ,
		S_DIVR,
		S_READ,
		S_MAP,
		S_FIN
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	// commands decoded from state
	always_comb begin
		cmd.cap  = in_valid && in_ready_q;
		cmd.mul  = (state_q == S_DIVQ);
		cmd.fix  = (state_q == S_DIVR);
		cmd.rd   = (state_q == S_READ);
		cmd.map  = (state_q == S_MAP);
		cmd.load = (state_q == S_FIN) && out_free;
	end

	// sequencer with registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// result word held until taken
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= S_DIVQ;
					end
				end
				S_DIVQ: begin
					state_q <= sts.need_map ? S_DIVR : S_FIN;
				end
				S_DIVR: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_MAP;
				end
				S_MAP: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						in_ready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// input side only open while idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> (state_q == S_IDLE))
		else $error("in_ready outside idle");

	// an accepted word closes the input side
	a_cap_closes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> !in_ready_q)
		else $error("input still open after accept");

	// a result appears only from the final step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result word not from final step");

endmodule

/* hdl/scam_dp.sv */
`timescale 1ns / 1ps

module scam_dp import scam_pkg::*; #(
	parameter int CHAIN_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  op,
	input  logic [7:0]  sector_track,
	input  logic [7:0]  sector_index,
	input  logic [7:0]  link_track,
	input  logic [7:0]  link_byte,
	input  logic [31:0] byte_offset,
	input  logic [15:0] span_request,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [2:0]  status,
	output logic [31:0] image_address,
	output logic [15:0] span_length,
	output logic        chain_closed,
	output logic [31:0] total_size
);

	localparam int AW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int CW = $clog2(CHAIN_DEPTH + 1);

	// configuration
	logic [1:0]  kind_q;
	logic [31:0] image_bytes_q;
	logic        writes_q;

	// chain state
	logic [CW-1:0] count_q;
	logic [7:0]    final_q;
	logic          closed_q;

	// captured word
	logic [2:0]  op_q;
	logic [7:0]  trk_q;
	logic [7:0]  sec_q;
	logic [7:0]  ltrk_q;
	logic [7:0]  lbyte_q;
	logic [31:0] off_q;
	logic [15:0] len_q;

	// lookup stages
	logic [QW-1:0]    quot_s1;
	logic [QW-1:0]    secn_q;
	logic [7:0]       within_q;
	logic             beyond_q;
	logic [7:0]       take_q;
	logic             map_bad_q;
	logic [31:0]      map_addr_q;
	logic [ENTRY_W-1:0] entry;

	// result word
	logic [2:0]  out_status_q;
	logic [31:0] out_addr_q;
	logic [15:0] out_span_q;
	logic        out_closed_q;
	logic [31:0] out_total_q;

	logic        d80;
	logic        flat;
	logic [62:0] prod;
	logic [32:0] rem;
	logic        last_sec;
	logic [7:0]  avail;
	logic [7:0]  diff;
	logic [11:0] base;
	logic [12:0] sec_sum;
	logic [20:0] soff;
	logic        flat_over;
	logic [2:0]  app_status;
	logic        app_ok;
	logic        ram_we;
	logic [2:0]  res_status;
	logic [31:0] res_addr;
	logic [15:0] res_span;
	logic [31:0] res_total;
	logic        closed_next;

	assign d80  = (kind_q == KIND_D80);
	assign flat = kind_q[1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= KIND_D64;
			image_bytes_q <= IMAGE_BYTES_RST;
			writes_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KIND:   kind_q        <= cfg_data[1:0];
				REG_BYTES:  image_bytes_q <= cfg_data;
				REG_WRITES: writes_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q    <= op;
			trk_q   <= sector_track;
			sec_q   <= sector_index;
			ltrk_q  <= link_track;
			lbyte_q <= link_byte;
			off_q   <= byte_offset;
			len_q   <= span_request;
		end
	end

	assign sts.need_map = (op_q == OP_READ || (op_q == OP_WRITE && writes_q)) &&
		!flat && closed_q && (len_q != 16'd0);

	// quotient estimate by reciprocal multiply
	assign prod = {32'd0, off_q[31:1]} * {31'd0, RECIP_127};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quot_s1 <= prod[RECIP_SHIFT +: QW];
		end
	end

	// remainder and one correction step
	assign rem = {1'b0, off_q} - {quot_s1, 8'd0} + {7'd0, quot_s1, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			if (rem >= {25'd0, DATA_BYTES}) begin
				secn_q   <= quot_s1 + 1'b1;
				within_q <= rem[7:0] - DATA_BYTES;
			end else begin
				secn_q   <= quot_s1;
				within_q <= rem[7:0];
			end
		end
	end

	// chain bounds and span within the sector
	assign last_sec = (secn_q == QW'(count_q - 1'b1));
	assign avail    = last_sec ? final_q : DATA_BYTES;
	assign diff     = avail - within_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			beyond_q <= (secn_q >= QW'(count_q)) || (within_q >= avail);
			take_q   <= (len_q < {8'd0, diff}) ? len_q[7:0] : diff;
		end
	end

	// link table
	assign ram_we = cmd.load && app_ok;

	scam_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CHAIN_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(count_q[AW-1:0]),
		.wr_data({trk_q[TRK_W-1:0], sec_q[SEC_W-1:0]}),
		.rd_en  (cmd.rd),
		.rd_addr(secn_q[AW-1:0]),
		.rd_data(entry)
	);

	// sector to image address
	assign base    = track_base(d80, entry[ENTRY_W-1:SEC_W]);
	assign sec_sum = {1'b0, base} + {8'd0, entry[SEC_W-1:0]};
	assign soff    = {sec_sum, 8'd0};

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			map_bad_q  <= ({12'd0, soff} + 33'd256) > {1'b0, image_bytes_q};
			map_addr_q <= {11'd0, soff} + 32'd2 + {24'd0, within_q};
		end
	end

	// append checks in priority order
	always_comb begin
		priority if (closed_q) app_status = ST_CLOSED;
		else if (count_q >= CW'(CHAIN_DEPTH)) app_status = ST_FULL;
		else if (trk_q == 8'd0 || trk_q > track_count(d80)) app_status = ST_TRACK;
		else if (sec_q >= {3'd0, zone_sectors(d80, trk_q)}) app_status = ST_SECTOR;
		else app_status = ST_OK;
	end

	assign app_ok    = (op_q == OP_APPEND) && (app_status == ST_OK);
	assign flat_over = ({1'b0, off_q} + {17'd0, len_q}) > {1'b0, image_bytes_q};

	// result of the word
	always_comb begin
		res_status  = ST_OK;
		res_addr    = 32'd0;
		res_span    = 16'd0;
		res_total   = 32'd0;
		closed_next = closed_q;
		unique case (op_q)
			OP_CLEAR: begin
				closed_next = 1'b0;
			end
			OP_APPEND: begin
				res_status = app_status;
				if (app_ok && ltrk_q == 8'd0) begin
					closed_next = 1'b1;
				end
			end
			OP_READ, OP_WRITE: begin
				priority if (op_q == OP_WRITE && !writes_q) begin
					res_status = ST_WRDIS;
				end else if (flat) begin
					if (flat_over) begin
						res_status = ST_IMAGE;
					end else begin
						res_addr = off_q;
						res_span = len_q;
					end
				end else if (!closed_q) begin
					res_status = ST_CLOSED;
				end else if (len_q == 16'd0) begin
					res_status = ST_OK;
				end else if (beyond_q) begin
					res_status = ST_CHAIN;
				end else if (map_bad_q) begin
					res_status = ST_IMAGE;
				end else begin
					res_addr = map_addr_q;
					res_span = {8'd0, take_q};
				end
			end
			OP_SIZE: begin
				if (flat) begin
					res_total = image_bytes_q;
				end else if (count_q != '0) begin
					res_total = 32'(count_q - 1'b1) * 32'd254 + {24'd0, final_q};
				end
			end
			default: ;
		endcase
	end

	// chain state update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			final_q  <= 8'd0;
			closed_q <= 1'b0;
		end else if (cmd.load) begin
			if (op_q == OP_CLEAR) begin
				count_q  <= '0;
				final_q  <= 8'd0;
				closed_q <= 1'b0;
			end else if (app_ok) begin
				count_q <= count_q + 1'b1;
				if (ltrk_q == 8'd0) begin
					final_q  <= (lbyte_q >= 8'd2) ? lbyte_q - 8'd1 : 8'd0;
					closed_q <= 1'b1;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= res_status;
			out_addr_q   <= res_addr;
			out_span_q   <= res_span;
			out_closed_q <= closed_next;
			out_total_q  <= res_total;
		end
	end

	assign status        = out_status_q;
	assign image_address = out_addr_q;
	assign span_length   = out_span_q;
	assign chain_closed  = out_closed_q;
	assign total_size    = out_total_q;

	// table never fills past its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CHAIN_DEPTH))
		else $error("link count beyond table depth");

	// a closed chain holds at least its final link
	a_closed_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> (count_q != '0))
		else $error("closed chain with no links");

endmodule

/* hdl/sector_chain_address_map.sv */
`timescale 1ns / 1ps

// Track/sector chain map for one file on a zoned disk image (D64 or D80), or
// a flat image mapped one to one.
// Input channel (in_valid/in_ready) takes one word per op: clear chain,
// append link, read lookup, write lookup or size query. Output channel
// (out_valid/out_ready) returns exactly one result word per input word.
// Config channel (cfg_valid/cfg_ready) is always ready; cfg_index selects
// image kind (0), image size in bytes (1) or write enable (2). Write it only
// while no word is in flight.
// Steps: a zoned lookup that reaches the table runs reciprocal multiply,
// remainder fix, table read, zone address sum and commit before the next
// accept; every other word goes from the multiply straight to commit. The
// sequence is set by the single controller and the one read port of the
// link table.
// The result sits in an output register; if the receiver stalls, the next
// word still gets through the pipeline and waits at commit until the output
// register is taken.
// Reset clears the chain (empty, open) and loads the register defaults; the
// link table itself needs no clearing since only entries below the link
// count are ever used.
module sector_chain_address_map import scam_pkg::*; #(
	parameter int CHAIN_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  sector_track,
	input  logic [7:0]  sector_index,
	input  logic [7:0]  link_track,
	input  logic [7:0]  link_byte,
	input  logic [31:0] byte_offset,
	input  logic [15:0] span_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] image_address,
	output logic [15:0] span_length,
	output logic        chain_closed,
	output logic [31:0] total_size
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	scam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// chain state, lookup arithmetic and result register
	scam_dp #(
		.CHAIN_DEPTH(CHAIN_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.sector_track (sector_track),
		.sector_index (sector_index),
		.link_track   (link_track),
		.link_byte    (link_byte),
		.byte_offset  (byte_offset),
		.span_request (span_request),
		.cmd          (cmd),
		.sts          (sts),
		.status       (status),
		.image_address(image_address),
		.span_length  (span_length),
		.chain_closed (chain_closed),
		.total_size   (total_size)
	);

endmodule
